/* src/nsfd_pkg.sv */
package nsfd_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  localparam int MANT_W  = 51;
  localparam int FRAC_W  = 4;
  localparam int PART_W  = 7;
  localparam int STORE_W = MANT_W + FRAC_W;
  localparam logic [PART_W-1:0] PART_MAX = 7'd127;
  localparam logic [3:0] FRAC_MAX = 4'd15;
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [63:0] MAG_CAP = (64'd1 << 50) - 64'd1;

  localparam logic [2:0] K_DEC  = 3'd0;
  localparam logic [2:0] K_INT  = 3'd1;
  localparam logic [2:0] K_CHR  = 3'd2;
  localparam logic [2:0] K_TRI  = 3'd3;
  localparam logic [2:0] K_NONE = 3'd4;

  localparam logic [1:0] MODE_RMC = 2'd0;
  localparam logic [1:0] MODE_GGA = 2'd1;
  localparam logic [1:0] MODE_THS = 2'd2;

  typedef struct packed {
    logic restart;
    logic body_xor;
    logic close;
    logic comma_adv;
    logic feed;
    logic latch_hex;
    logic emit_start;
    logic rd_en;
    logic load;
    logic idx_inc;
  } nsfd_cmd_t;

  typedef struct packed {
    logic is_dollar;
    logic is_star;
    logic is_comma;
    logic hex_match;
    logic cur_present;
    logic idx_at_end;
    logic out_free;
  } nsfd_status_t;

  function automatic logic [63:0] digit_limit(input int digits);
    logic [63:0] l;
    l = 64'd1;
    for (int i = 0; i < 18; i++) begin
      if (i < digits) l = l * 64'd10;
    end
    l = l - 64'd1;
    return (l > MAG_CAP) ? MAG_CAP : l;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? (CH_ZERO + 8'(nib)) : (CH_UPPER_A + 8'(nib) - 8'd10);
  endfunction

  function automatic logic [2:0] kind_of(input logic [1:0] sk, input logic [3:0] n);
    logic [2:0] k;
    k = K_NONE;
    case (sk)
      MODE_RMC: begin
        case (n)
          4'd1, 4'd9: k = K_TRI;
          4'd2, 4'd4, 4'd6, 4'd11, 4'd12, 4'd13: k = K_CHR;
          4'd3, 4'd5, 4'd7, 4'd8, 4'd10: k = K_DEC;
          default: k = K_NONE;
        endcase
      end
      MODE_GGA: begin
        case (n)
          4'd1: k = K_TRI;
          4'd2, 4'd4, 4'd8, 4'd9, 4'd11: k = K_DEC;
          4'd3, 4'd5, 4'd6: k = K_CHR;
          4'd7, 4'd14: k = K_INT;
          default: k = K_NONE;
        endcase
      end
      MODE_THS: begin
        k = (n == 4'd1) ? K_DEC : K_NONE;
      end
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

/* src/nsfd_if.sv */
interface nsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [1:0] mode;
  modport source (output valid, rx_byte, mode, input ready);
  modport sink (input valid, rx_byte, mode, output ready);
endinterface

interface nsfd_field_if;
  logic               valid;
  logic               ready;
  logic [3:0]         field_number;
  logic [1:0]         field_kind;
  logic signed [50:0] mantissa;
  logic [3:0]         fraction_digits;
  logic [7:0]         char_value;
  logic [6:0]         part_first;
  logic [6:0]         part_second;
  logic [6:0]         part_third;
  logic               last_field;
  modport source (output valid, field_number, field_kind, mantissa, fraction_digits,
                  char_value, part_first, part_second, part_third, last_field,
                  input ready);
  modport sink (input valid, field_number, field_kind, mantissa, fraction_digits,
                char_value, part_first, part_second, part_third, last_field,
                output ready);
endinterface

/* src/nsfd_ram.sv */
module nsfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/nsfd_ctrl.sv */
module nsfd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  nsfd_pkg::nsfd_status_t st,
  output nsfd_pkg::nsfd_cmd_t    cmd
);
  import nsfd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_BODY, S_HEX1, S_HEX2, S_RD, S_CHK} state_t;

  state_t state;
  state_t state_next;
  logic   acc;

  assign in_ready = (state == S_IDLE) || (state == S_BODY) ||
                    (state == S_HEX1) || (state == S_HEX2);
  assign acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    if (acc && st.is_dollar) begin
      cmd.restart = 1'b1;
      state_next = S_BODY;
    end else begin
      case (state)
        S_BODY: begin
          if (acc) begin
            if (st.is_star) begin
              cmd.close = 1'b1;
              state_next = S_HEX1;
            end else if (st.is_comma) begin
              cmd.body_xor = 1'b1;
              cmd.close = 1'b1;
              cmd.comma_adv = 1'b1;
            end else begin
              cmd.body_xor = 1'b1;
              cmd.feed = 1'b1;
            end
          end
        end
        S_HEX1: begin
          if (acc) begin
            cmd.latch_hex = 1'b1;
            state_next = S_HEX2;
          end
        end
        S_HEX2: begin
          if (acc) begin
            if (st.hex_match) begin
              cmd.emit_start = 1'b1;
              state_next = S_RD;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
        S_RD: begin
          cmd.rd_en = 1'b1;
          state_next = S_CHK;
        end
        S_CHK: begin
          if (!st.cur_present || st.out_free) begin
            cmd.load = st.cur_present;
            if (st.idx_at_end) begin
              state_next = S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
              state_next = S_RD;
            end
          end
        end
        default: state_next = state;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* src/nsfd_datapath.sv */
module nsfd_datapath #(
  parameter int FIELD_SLOTS = 16,
  parameter int MAX_DIGITS = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [4:0]             cfg_data,
  nsfd_byte_if.sink              rx,
  nsfd_field_if.source           fo,
  input  nsfd_pkg::nsfd_cmd_t    cmd,
  output nsfd_pkg::nsfd_status_t st
);
  import nsfd_pkg::*;

  localparam int AW = $clog2(FIELD_SLOTS);
  localparam logic [55:0] LIMIT = 56'(digit_limit(MAX_DIGITS));
  localparam logic [3:0] LAST_IDX = (FIELD_SLOTS > 15) ? 4'd15 : 4'(FIELD_SLOTS - 1);

  logic [4:0]             hour_offset;
  logic [1:0]             skind;
  logic [7:0]             xsum;
  logic [3:0]             comma_count;
  logic [MANT_W-1:0]      accum;
  logic                   point_seen;
  logic                   negative;
  logic [3:0]             frac_count;
  logic [3:0]             char_pos;
  logic [2:0][PART_W-1:0] parts;
  logic [7:0]             rx_hex;
  logic [FIELD_SLOTS-1:0] present;
  logic                   stopped;
  logic                   pair_lead;
  logic [3:0]             idx;
  logic                   out_valid;

  logic [7:0]         b;
  logic [2:0]         kind;
  logic               dig;
  logic [3:0]         dval;
  logic [55:0]        nv;
  logic               nv_ok;
  logic [MANT_W-1:0]  mag;
  logic [7:0]         hsum;
  logic [PART_W-1:0]  first_part;
  logic [STORE_W-1:0] wword;
  logic               wen;
  logic [STORE_W-1:0] rword;
  logic [2:0]         okind;
  logic [1:0]         psel;
  logic [PART_W-1:0]  pcur;
  logic [31:0]        above;

  assign b = rx.rx_byte;
  assign kind = kind_of(skind, comma_count);
  assign dig = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval = b[3:0];
  assign nv = (56'(accum) << 3) + (56'(accum) << 1) + 56'(dval);
  assign nv_ok = nv <= LIMIT;
  assign psel = char_pos[2:1];
  assign pcur = parts[psel];

  assign mag = negative ? (MANT_W'(0) - accum) : accum;
  assign hsum = 8'(parts[0]) + ((comma_count == 4'd1) ? 8'(hour_offset) : 8'd0);
  assign first_part = (hsum > 8'(PART_MAX)) ? PART_MAX : hsum[PART_W-1:0];

  always_comb begin
    case (kind)
      K_DEC, K_INT: wword = {frac_count, mag};
      K_TRI: wword = STORE_W'({parts[2], parts[1], first_part});
      default: wword = STORE_W'({parts[1][0], parts[0]});
    endcase
  end

  assign wen = cmd.close && (kind != K_NONE) && (32'(comma_count) < FIELD_SLOTS);

  nsfd_ram #(.WIDTH(STORE_W), .DEPTH(FIELD_SLOTS)) u_store (
    .clk   (clk),
    .we    (wen),
    .waddr (AW'(comma_count)),
    .wdata (wword),
    .re    (cmd.rd_en),
    .raddr (AW'(idx)),
    .rdata (rword)
  );

  assign above = 32'(present) >> (32'(idx) + 32'd1);
  assign okind = kind_of(skind, idx);

  assign st.is_dollar = (b == CH_DOLLAR);
  assign st.is_star = (b == CH_STAR);
  assign st.is_comma = (b == CH_COMMA);
  assign st.hex_match = (rx_hex == hex_char(xsum[7:4])) && (b == hex_char(xsum[3:0]));
  assign st.cur_present = present[AW'(idx)];
  assign st.idx_at_end = (idx == LAST_IDX);
  assign st.out_free = !out_valid || fo.ready;

  assign fo.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_offset <= 5'd8;
    end else if (cfg_we) begin
      hour_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skind <= '0;
      xsum <= '0;
      comma_count <= '0;
      accum <= '0;
      point_seen <= 1'b0;
      negative <= 1'b0;
      frac_count <= '0;
      char_pos <= '0;
      parts <= '0;
      rx_hex <= '0;
      present <= '0;
      stopped <= 1'b0;
      pair_lead <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fo.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.restart) begin
        skind <= rx.mode;
        xsum <= '0;
        comma_count <= '0;
        present <= '0;
      end
      if (cmd.body_xor) begin
        xsum <= xsum ^ b;
      end
      if (wen) begin
        present[AW'(comma_count)] <= 1'b1;
      end
      if (cmd.comma_adv && (comma_count < COUNT_MAX)) begin
        comma_count <= comma_count + 4'd1;
      end
      if (cmd.restart || cmd.comma_adv) begin
        accum <= '0;
        point_seen <= 1'b0;
        negative <= 1'b0;
        frac_count <= '0;
        char_pos <= '0;
        parts <= '0;
        stopped <= 1'b0;
        pair_lead <= 1'b0;
      end
      if (cmd.feed) begin
        if ((kind == K_DEC) || (kind == K_INT)) begin
          if (!stopped) begin
            if (dig) begin
              if (point_seen) begin
                if ((frac_count < FRAC_MAX) && nv_ok) begin
                  accum <= nv[MANT_W-1:0];
                  frac_count <= frac_count + 4'd1;
                end
              end else if (nv_ok) begin
                accum <= nv[MANT_W-1:0];
              end else begin
                accum <= LIMIT[MANT_W-1:0];
                stopped <= 1'b1;
              end
            end else if ((char_pos == 4'd0) && ((b == CH_MINUS) || (b == CH_PLUS))) begin
              if (b == CH_MINUS) negative <= 1'b1;
            end else if ((b == CH_POINT) && (kind == K_DEC) && !point_seen) begin
              point_seen <= 1'b1;
            end else begin
              stopped <= 1'b1;
            end
          end
        end else if (kind == K_CHR) begin
          if (char_pos == 4'd0) parts <= 21'(b);
        end else if ((kind == K_TRI) && (char_pos < 4'd6)) begin
          if (!char_pos[0]) begin
            parts[psel] <= dig ? PART_W'(dval) : '0;
            pair_lead <= dig;
          end else if (pair_lead && dig) begin
            parts[psel] <= PART_W'((pcur << 3) + (pcur << 1) + PART_W'(dval));
          end
        end
        if (char_pos < COUNT_MAX) char_pos <= char_pos + 4'd1;
      end
      if (cmd.latch_hex) begin
        rx_hex <= b;
      end
      if (cmd.emit_start) begin
        idx <= 4'd1;
      end
      if (cmd.idx_inc) begin
        idx <= idx + 4'd1;
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fo.field_number <= idx;
      fo.field_kind <= okind[1:0];
      fo.mantissa <= '0;
      fo.fraction_digits <= '0;
      fo.char_value <= '0;
      fo.part_first <= '0;
      fo.part_second <= '0;
      fo.part_third <= '0;
      fo.last_field <= (above == 32'd0);
      case (okind)
        K_DEC: begin
          fo.mantissa <= rword[MANT_W-1:0];
          fo.fraction_digits <= rword[STORE_W-1:MANT_W];
        end
        K_INT: fo.mantissa <= rword[MANT_W-1:0];
        K_CHR: fo.char_value <= rword[7:0];
        default: begin
          fo.part_first <= rword[PART_W-1:0];
          fo.part_second <= rword[2*PART_W-1:PART_W];
          fo.part_third <= rword[3*PART_W-1:2*PART_W];
        end
      endcase
    end
  end
endmodule

/* src/nmea_sentence_field_decoder_core.sv */
// Bytes are taken at one per cycle, so they may arrive back to back while a
// sentence is being received. After the second checksum byte of a sentence whose
// checksum matches, the controller walks the field store in field order, a RAM read
// state and a check state per field slot, for slots 1 to 15; the check of a present
// slot waits while the output holds a result not yet taken. No byte is accepted during
// that walk. The last result waits in its output register while bytes flow again.
module nmea_sentence_field_decoder_core #(
  parameter int FIELD_SLOTS = 16,
  parameter int MAX_DIGITS = 15
) (
  input logic          clk,
  input logic          rst,
  input logic          cfg_we,
  input logic [4:0]    cfg_data,
  nsfd_byte_if.sink    rx,
  nsfd_field_if.source fo
);
  import nsfd_pkg::*;

  nsfd_cmd_t    cmd;
  nsfd_status_t st;

  nsfd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .st       (st),
    .cmd      (cmd)
  );

  nsfd_datapath #(.FIELD_SLOTS(FIELD_SLOTS), .MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .rx       (rx),
    .fo       (fo),
    .cmd      (cmd),
    .st       (st)
  );

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> st.out_free) else $error("result loaded over a waiting result");
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> fo.valid) else $error("loaded result not presented");
  a_read_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> !rx.ready) else $error("byte accepted during field walk");
`endif
endmodule
